// ===== sv/fp32a_pkg.sv =====
// Shared constants for the single-precision adder.
package fp32a_pkg;
  localparam int WORD_BITS  = 32;
  localparam int EXTRA_BITS = 3;
endpackage

// ===== sv/fp32_adder.sv =====
// Top level: four-stage pipelined single-precision adder.
// Usage:
//   Input channel in_valid/in_ready carries in_operand_a and in_operand_b.
//   Output channel out_valid/out_ready carries out_sum_word, out_overflow_flag
//   and out_underflow_flag, one result per input transfer, in order.
//   After the input transfer a pair moves through the stage 1 to stage 4
//   registers, and out_valid is the stage 4 valid bit. Throughput is one
//   pair per cycle while out_ready stays high; the pipeline advances one
//   stage whenever its output register is empty or is being taken.
//   Stage 1 compares and swaps the operands, stage 2 aligns and adds,
//   stage 3 normalises by carry or leading zeros, stage 4 rounds and packs.
//   The leading-zero count in stage 3 sets the longest path.
//   On a receiver stall the output stage holds and bubbles behind it fill;
//   in_ready falls only with every stage full; nothing is lost or repeated.
//   Synchronous reset clears all stage valid bits; payload is not reset.
//   Denormals, infinities and NaN are treated as ordinary normal numbers.
module fp32_adder #(
  parameter int FRACTION_BITS = 23
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_word,
  output logic        out_overflow_flag,
  output logic        out_underflow_flag
);
  import fp32a_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int EB    = WORD_BITS - 1 - FB;
  localparam int SW    = FB + 1 + EXTRA_BITS;   // aligned significand width
  localparam int DW    = EB;                    // exponent difference width
  localparam int CW    = $clog2(SW + 2);
  localparam int XW    = ((EB > CW) ? EB : CW) + 2;   // signed working exponent
  localparam logic [EB-1:0] EMAX = {{(EB-1){1'b1}}, 1'b0};

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !v4_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // stage 1: compare and swap
  logic          sa, sb;
  logic [EB-1:0] ea, eb;
  logic [FB-1:0] fa, fb;
  assign sa = in_operand_a[31];
  assign sb = in_operand_b[31];
  assign ea = in_operand_a[30:FB];
  assign eb = in_operand_b[30:FB];
  assign fa = in_operand_a[FB-1:0];
  assign fb = in_operand_b[FB-1:0];

  logic          s1_cancel_r, s1_sub_r, s1_sign_r;
  logic [EB-1:0] s1_ebig_r;
  logic [DW-1:0] s1_d_r;
  logic [FB:0]   s1_big_r, s1_small_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
    if (adv1) begin
      s1_cancel_r <= (ea == eb) && (fa == fb) && (sa != sb);
      s1_sub_r    <= sa != sb;
      if (ea > eb || (ea == eb && fa >= fb)) begin
        s1_ebig_r  <= ea;
        s1_d_r     <= ea - eb;
        s1_big_r   <= {1'b1, fa};
        s1_small_r <= {1'b1, fb};
        s1_sign_r  <= sa;
      end else begin
        s1_ebig_r  <= eb;
        s1_d_r     <= eb - ea;
        s1_big_r   <= {1'b1, fb};
        s1_small_r <= {1'b1, fa};
        s1_sign_r  <= sb;
      end
    end
  end

  // stage 2: align with sticky, add or subtract
  logic [SW-1:0] big_x, small_x, small_al;
  always_comb begin
    logic [SW-1:0] lostm;
    big_x   = {s1_big_r, {EXTRA_BITS{1'b0}}};
    small_x = {s1_small_r, {EXTRA_BITS{1'b0}}};
    lostm   = ~({SW{1'b1}} << s1_d_r);
    if ({{CW{1'b0}}, s1_d_r} >= (DW+CW)'(SW)) begin
      small_al = SW'(1);
    end else begin
      small_al = (small_x >> s1_d_r) | SW'(|(small_x & lostm));
    end
  end

  logic          s2_cancel_r, s2_sign_r;
  logic [EB-1:0] s2_ebig_r;
  logic [SW:0]   s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2) begin
      s2_cancel_r <= s1_cancel_r;
      s2_sign_r   <= s1_sign_r;
      s2_ebig_r   <= s1_ebig_r;
      s2_sum_r    <= s1_sub_r ? ({1'b0, big_x} - {1'b0, small_al})
                              : ({1'b0, big_x} + {1'b0, small_al});
    end
  end

  // stage 3: normalise
  logic [CW-1:0] lz;
  logic          lz_zero;
  fp32a_lzc #(.WIDTH(SW), .CNT_W(CW)) u_lzc (
    .vec      (s2_sum_r[SW-1:0]),
    .count    (lz),
    .all_zero (lz_zero)
  );

  logic          s3_cancel_r, s3_sign_r;
  logic [XW-1:0] s3_ex_r;
  logic [SW-1:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
    if (adv3) begin
      s3_cancel_r <= s2_cancel_r;
      s3_sign_r   <= s2_sign_r;
      if (s2_sum_r[SW]) begin
        s3_sum_r <= s2_sum_r[SW:1] | SW'(s2_sum_r[0]);
        s3_ex_r  <= XW'(s2_ebig_r) + XW'(1);
      end else begin
        // all-zero sum shifts the full loop length, the whole width
        s3_sum_r <= lz_zero ? '0 : (s2_sum_r[SW-1:0] << lz);
        s3_ex_r  <= XW'(s2_ebig_r) - (lz_zero ? XW'(SW) : XW'(lz));
      end
    end
  end

  // stage 4: round to nearest even and pack
  logic [FB+1:0] m_rnd;
  logic [XW-1:0] ex_fin;
  logic [FB:0]   m_fin;
  logic          ovf, unf;
  logic [31:0]   word;
  always_comb begin
    logic [FB:0] m0;
    m0    = s3_sum_r[SW-1:EXTRA_BITS];
    m_rnd = {1'b0, m0} +
            (FB+2)'(s3_sum_r[2] && ((|s3_sum_r[1:0]) || m0[0]));
    if (m_rnd[FB+1]) begin
      m_fin  = m_rnd[FB+1:1];
      ex_fin = s3_ex_r + XW'(1);
    end else begin
      m_fin  = m_rnd[FB:0];
      ex_fin = s3_ex_r;
    end
    ovf  = $signed(ex_fin) > $signed(XW'(EMAX));
    unf  = $signed(ex_fin) < $signed(XW'(1));
    word = {s3_sign_r, 31'b0};
    if (ovf) begin
      word[30:FB] = {EB{1'b1}};
    end else if (!unf) begin
      word[30:FB]   = ex_fin[EB-1:0];
      word[FB-1:0]  = m_fin[FB-1:0];
    end
    if (s3_cancel_r) begin
      word = '0;
      ovf  = 1'b0;
      unf  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv4) begin
      v4_r <= v3_r;
    end
    if (adv4) begin
      out_sum_word       <= word;
      out_overflow_flag  <= ovf;
      out_underflow_flag <= unf;
    end
  end

  assign out_valid = v4_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_word))
    else $error("result changed while stalled");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && !out_ready)
    else $error("input stalled with room in pipeline");
  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    adv4 && v3_r && s3_cancel_r |=> out_sum_word == '0)
    else $error("cancellation not zero");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow_flag && out_underflow_flag))
    else $error("both flags set");
endmodule

// ===== sv/fp32a_lzc.sv =====
// Leading-zero counter over the working sum, combinational priority scan.
module fp32a_lzc #(
  parameter int WIDTH = 27,
  parameter int CNT_W = 5
) (
  input  logic [WIDTH-1:0] vec,
  output logic [CNT_W-1:0] count,
  output logic             all_zero
);
  import fp32a_pkg::*;

  always_comb begin
    logic found;
    found    = 1'b0;
    count    = CNT_W'(WIDTH);
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!found && vec[i]) begin
        found = 1'b1;
        count = CNT_W'(WIDTH - 1 - i);
      end
    end
    all_zero = !found;
  end
endmodule

// ===== bench/tb_fp32_adder.sv =====
// Self-checking bench for the pipelined single-precision adder.
module tb_fp32_adder;
  import fp32a_pkg::*;

  localparam int FRAC   = 23;
  localparam int EXPB   = WORD_BITS - 1 - FRAC;
  localparam int LATENCY = 4;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [31:0] sum_word;
    logic        ovf;
    logic        unf;
  } fp_sum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sum_word;
  logic        out_overflow_flag;
  logic        out_underflow_flag;

  fp_sum_t expected_sums[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      rx_stall_on = 1'b1;

  fp32_adder #(.FRACTION_BITS(FRAC)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sum of two words, every exponent read as normal with a hidden one.
  function automatic fp_sum_t predict_sum(logic [31:0] a, logic [31:0] b);
    fp_sum_t     r;
    logic        sa, sb, sgn;
    logic [EXPB-1:0] ea, eb, ebig, esml;
    logic [FRAC-1:0] fa, fb;
    logic [63:0] big, sml, lost, total, m;
    int          d, ex, n;
    sa = a[31]; sb = b[31];
    ea = a[30:FRAC]; eb = b[30:FRAC];
    fa = a[FRAC-1:0]; fb = b[FRAC-1:0];
    r = '0;
    if (ea == eb && fa == fb && sa != sb) return r;
    if (ea > eb || (ea == eb && fa >= fb)) begin
      ebig = ea; esml = eb; big = {1'b1, fa}; sml = {1'b1, fb}; sgn = sa;
    end else begin
      ebig = eb; esml = ea; big = {1'b1, fb}; sml = {1'b1, fa}; sgn = sb;
    end
    big = big << EXTRA_BITS;
    sml = sml << EXTRA_BITS;
    d = int'(ebig) - int'(esml);
    if (d >= FRAC + 1 + EXTRA_BITS) sml = 64'd1;
    else if (d > 0) begin
      lost = sml & ((64'd1 << d) - 1);
      sml = (sml >> d) | 64'(lost != 0);
    end
    total = (sa == sb) ? big + sml : big - sml;
    ex = int'(ebig);
    if (total[FRAC+1+EXTRA_BITS]) begin
      total = (total >> 1) | (total & 64'd1);
      ex++;
    end else begin
      n = 0;
      while (!total[FRAC+EXTRA_BITS] && n < FRAC + EXTRA_BITS + 1) begin
        total = total << 1; ex--; n++;
      end
    end
    m = total >> EXTRA_BITS;
    if (total[2] && (total[1:0] != 0 || m[0])) m = m + 1;
    if (m[FRAC+1]) begin
      m = m >> 1; ex++;
    end
    r.ovf = ex > (2 ** EXPB) - 2;
    r.unf = ex < 1;
    r.sum_word[31] = sgn;
    if (r.ovf) r.sum_word[30:FRAC] = '1;
    else if (!r.unf) r.sum_word[30:0] = {ex[EXPB-1:0], m[FRAC-1:0]};
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Result side: random stalls if enabled; each transfer checked vs queue head.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_sum_word);
        errors++;
      end else begin
        fp_sum_t e;
        e = expected_sums.pop_front();
        if (e.sum_word !== out_sum_word) begin
          $display("%0t sum_word exp %h got %h", $time, e.sum_word, out_sum_word);
          errors++;
        end
        if (e.ovf !== out_overflow_flag) begin
          $display("%0t overflow exp %b got %b", $time, e.ovf, out_overflow_flag);
          errors++;
        end
        if (e.unf !== out_underflow_flag) begin
          $display("%0t underflow exp %b got %b", $time, e.unf, out_underflow_flag);
          errors++;
        end
      end
    end
    if (!rx_stall_on) out_ready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else if (!out_ready && $urandom_range(0, 3) != 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  // valid stays up between back-to-back transfers; it drops only for a gap
  task automatic send_pair(logic [31:0] a, logic [31:0] b, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    expected_sums.push_back(predict_sum(a, b));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
  endtask

  function automatic logic [31:0] mk(bit s, int e, int f);
    return {s, e[7:0], f[22:0]};
  endfunction

  task automatic test_directed();
    send_pair(32'h3f80_0000, 32'h3f80_0000, 0);
    send_pair(32'h3f80_0000, 32'hbf80_0000, 0);  // exact cancellation
    send_pair(32'hc2c8_1234, 32'h42c8_1234, 0);
    send_pair(32'h0000_0000, 32'h0000_0000, 0);  // zero field as normal
    send_pair(32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h0000_0000, 32'h8000_0001, 0);  // underflow
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 0);  // overflow
    send_pair(32'hff80_0000, 32'hff7f_ffff, 0);  // all-ones exponent
    send_pair(32'h7f7f_ffff, 32'h7f7f_ffff, 0);
    send_pair(32'h3f80_0000, 32'h3380_0000, 0);  // tie to even
    send_pair(32'h3f80_0001, 32'h3380_0000, 0);
    send_pair(32'h3f80_0000, 32'h3380_0001, 0);  // sticky
    send_pair(32'h4b00_0000, 32'h0000_0001, 0);  // far alignment
    send_pair(32'h3fff_ffff, 32'h3400_0000, 0);  // rounding carry
    send_pair(32'h3f80_0000, 32'hbf7f_ffff, 0);  // deep renormalisation
    send_pair(32'h4040_0000, 32'hc000_0000, 0);
    send_pair(32'hbf80_0000, 32'h3f00_0000, 0);
    send_pair(32'hffff_ffff, 32'h0000_0000, 0);
  endtask

  task automatic test_random(int count);
    int e1, k;
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 4);
      a = $urandom();
      b = $urandom();
      e1 = $urandom_range(0, 255);
      if (k == 1) b = mk($urandom_range(0, 1), e1 + $urandom_range(0, 3) - 1,
                         $urandom());
      if (k == 1) a = mk($urandom_range(0, 1), e1, $urandom());
      if (k == 2) b = {~a[31], a[30:0] ^ 31'($urandom_range(0, 3))};
      if (k == 3) a = mk(a[31], $urandom_range(0, 1) ? 254 : 1, a[22:0]);
      send_pair(a, b, 1);
      if (i == count / 2) drain();  // let the pipeline empty mid-run
    end
  endtask

  task automatic test_full_rate(int count);
    rx_stall_on = 1'b0;
    for (int i = 0; i < count; i++) send_pair($urandom(), $urandom(), 0);
    drain();
    rx_stall_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(520);
    test_full_rate(80);
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
